[sv/afp_pkg.sv]
`timescale 1ns / 1ps
// afp_pkg: types, character codes, tag codes and digit limits
// for the anemometer field parser. No dependencies.
package afp_pkg;

    localparam int MAX_DIGITS = 9;
    localparam int EFF_LO     = (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
    localparam int EFF_DIGITS = (EFF_LO > 9) ? 9 : EFF_LO;

    localparam int MAG_W  = 30;
    localparam int MANT_W = 31;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SKIP = 3'd1,
        PH_PSEL = 3'd2,
        PH_LEAD = 3'd3,
        PH_BODY = 3'd4
    } phase_t;

    localparam logic [3:0] TAG_SPEED    = 4'd0;
    localparam logic [3:0] TAG_DIR      = 4'd1;
    localparam logic [3:0] TAG_U        = 4'd2;
    localparam logic [3:0] TAG_V        = 4'd3;
    localparam logic [3:0] TAG_W        = 4'd4;
    localparam logic [3:0] TAG_TEMP     = 4'd5;
    localparam logic [3:0] TAG_HUMIDITY = 4'd6;
    localparam logic [3:0] TAG_PRESSURE = 4'd7;
    localparam logic [3:0] TAG_PITCH    = 4'd8;
    localparam logic [3:0] TAG_ROLL     = 4'd9;
    localparam logic [3:0] TAG_MAGDIR   = 4'd10;
    localparam logic [3:0] TAG_P        = 4'd14;
    localparam logic [3:0] TAG_NONE     = 4'd15;

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    function automatic logic [MAG_W-1:0] digit_limit_f();
        logic [MAG_W-1:0] v;
        v = MAG_W'(1);
        for (int i = 0; i < EFF_DIGITS; i++)
        begin
            v = MAG_W'(v * 10);
        end
        return v - 1'b1;
    endfunction

    localparam logic [MAG_W-1:0] DIGIT_LIMIT = digit_limit_f();
    localparam logic [3:0]       DIGIT_MAX   = 4'(EFF_DIGITS);

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_tag_byte(input logic [7:0] c);
        return !is_ws(c) && !is_digit(c) && (c != CH_DOT) && (c != CH_MINUS);
    endfunction

    function automatic logic [3:0] tag_of(input logic [7:0] c);
        logic [3:0] t;
        case (c)
            CH_S:    t = TAG_SPEED;
            CH_D:    t = TAG_DIR;
            CH_U:    t = TAG_U;
            CH_V:    t = TAG_V;
            CH_W:    t = TAG_W;
            CH_T:    t = TAG_TEMP;
            CH_H:    t = TAG_HUMIDITY;
            CH_R:    t = TAG_ROLL;
            CH_M:    t = TAG_MAGDIR;
            CH_P:    t = TAG_P;
            default: t = TAG_NONE;
        endcase
        return t;
    endfunction

endpackage

[sv/anemometer_field_parser_unit.sv]
`timescale 1ns / 1ps
// anemometer_field_parser_unit: byte-wise parser of tagged decimal fields.
// Depends on afp_pkg.
//
//   channel | handshake         | words
//   --------+-------------------+------------------------------------------
//   input   | in_valid/in_ready | char_byte, last_byte
//   output  | out_valid/ready   | field_valid, field_id, value_mantissa,
//           |                   | fraction_digits, value_overflow,
//           |                   | sentence_end
//
// One byte per cycle sustained while the output is not stalled; the result word for a byte
// is written after the byte passes the input register and then the parse step.
// The parse step advances whenever the input register holds a byte and the result register is empty or drained.
// A stalled output holds the input register and so drops in_ready.
// Reset returns the parser to idle with cleared accumulators.
module anemometer_field_parser_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     char_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           field_valid,
    output logic [3:0]                     field_id,
    output logic signed [afp_pkg::MANT_W-1:0] value_mantissa,
    output logic [3:0]                     fraction_digits,
    output logic                           value_overflow,
    output logic                           sentence_end
);
    import afp_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             advance;

    phase_t           phase_reg, phase_next;
    logic [3:0]       tag_reg, tag_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             point_reg, point_next;
    logic [3:0]       frac_reg, frac_next;
    logic [3:0]       count_reg, count_next;
    logic             sat_reg, sat_next;

    logic             emit;
    logic             do_idle;
    logic             tag_load;
    logic [3:0]       tag_val;
    logic             num_clear;
    logic             sign_load;
    logic             point_set;
    logic             digit_take;

    logic [MAG_W-1:0] mag_step;
    logic             neg_step;
    logic             point_step;
    logic [3:0]       frac_step;
    logic [3:0]       count_step;
    logic             sat_step;
    logic [3:0]       digit;
    logic [MAG_W-1:0] mag_times_ten;
    logic [MAG_W-1:0] signed_mag;

    logic             out_valid_reg;
    logic             fvalid_reg;
    logic [3:0]       fid_reg;
    logic [MANT_W-1:0] mant_reg;
    logic [3:0]       fdig_reg;
    logic             ovf_reg;
    logic             send_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_byte;
            last_reg <= last_byte;
        end
    end

    // next phase and per-byte actions
    always_comb
    begin
        phase_next = phase_reg;
        emit       = 1'b0;
        do_idle    = 1'b0;
        tag_load   = 1'b0;
        tag_val    = tag_reg;
        num_clear  = 1'b0;
        sign_load  = 1'b0;
        point_set  = 1'b0;
        digit_take = 1'b0;
        unique case (phase_reg)
            PH_SKIP:
            begin
                phase_next = PH_LEAD;
            end
            PH_PSEL:
            begin
                if (char_reg == CH_I)
                begin
                    tag_load   = 1'b1;
                    tag_val    = TAG_PITCH;
                    phase_next = PH_LEAD;
                end
                else if (char_reg == CH_SPACE)
                begin
                    tag_load   = 1'b1;
                    tag_val    = TAG_PRESSURE;
                    phase_next = PH_LEAD;
                end
                else
                begin
                    do_idle = 1'b1;
                end
            end
            PH_LEAD:
            begin
                if (is_ws(char_reg))
                begin
                    phase_next = PH_LEAD;
                end
                else if ((char_reg == CH_PLUS) || (char_reg == CH_MINUS))
                begin
                    sign_load  = 1'b1;
                    phase_next = PH_BODY;
                end
                else if (is_digit(char_reg))
                begin
                    digit_take = 1'b1;
                    phase_next = PH_BODY;
                end
                else if (char_reg == CH_DOT)
                begin
                    point_set  = 1'b1;
                    phase_next = PH_BODY;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_BODY:
            begin
                if (is_digit(char_reg))
                begin
                    digit_take = 1'b1;
                end
                else if ((char_reg == CH_DOT) && !point_reg)
                begin
                    point_set = 1'b1;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle)
        begin
            phase_next = PH_IDLE;
            if (is_tag_byte(char_reg))
            begin
                if (tag_of(char_reg) <= TAG_MAGDIR)
                begin
                    tag_load   = 1'b1;
                    tag_val    = tag_of(char_reg);
                    num_clear  = 1'b1;
                    phase_next = PH_SKIP;
                end
                else if (tag_of(char_reg) == TAG_P)
                begin
                    num_clear  = 1'b1;
                    phase_next = PH_PSEL;
                end
            end
        end

        if (last_reg && ((phase_next == PH_LEAD) || (phase_next == PH_BODY)))
        begin
            emit = 1'b1;
        end
    end

    assign digit         = char_reg[3:0];
    assign mag_times_ten = {mag_reg[MAG_W-4:0], 3'b000} + {mag_reg[MAG_W-2:0], 1'b0};

    // accumulator update for one byte
    always_comb
    begin
        mag_step   = mag_reg;
        neg_step   = neg_reg;
        point_step = point_reg;
        frac_step  = frac_reg;
        count_step = count_reg;
        sat_step   = sat_reg;
        if (num_clear)
        begin
            mag_step   = '0;
            neg_step   = 1'b0;
            point_step = 1'b0;
            frac_step  = '0;
            count_step = '0;
            sat_step   = 1'b0;
        end
        if (sign_load)
        begin
            neg_step = (char_reg == CH_MINUS);
        end
        if (point_set)
        begin
            point_step = 1'b1;
        end
        if (digit_take)
        begin
            if (!point_reg && (mag_reg == '0) && (digit == 4'd0))
            begin
                mag_step = mag_reg;
            end
            else if (count_reg >= DIGIT_MAX)
            begin
                mag_step = DIGIT_LIMIT;
                sat_step = 1'b1;
            end
            else if (!sat_reg)
            begin
                mag_step   = mag_times_ten + {{(MAG_W-4){1'b0}}, digit};
                count_step = count_reg + 4'd1;
                if (point_reg)
                begin
                    frac_step = frac_reg + 4'd1;
                end
            end
        end

        tag_next = tag_load ? tag_val : tag_reg;
        if (last_reg)
        begin
            mag_next   = '0;
            neg_next   = 1'b0;
            point_next = 1'b0;
            frac_next  = '0;
            count_next = '0;
            sat_next   = 1'b0;
        end
        else
        begin
            mag_next   = mag_step;
            neg_next   = neg_step;
            point_next = point_step;
            frac_next  = frac_step;
            count_next = count_step;
            sat_next   = sat_step;
        end
    end

    assign signed_mag = neg_step ? (MAG_W'(0) - mag_step) : mag_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tag_reg   <= '0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            frac_reg  <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= last_reg ? PH_IDLE : phase_next;
            tag_reg   <= tag_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            frac_reg  <= frac_next;
            count_reg <= count_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit || last_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fvalid_reg <= emit;
            fid_reg    <= emit ? tag_next : 4'd0;
            mant_reg   <= emit ? {neg_step && (mag_step != '0), signed_mag} : '0;
            fdig_reg   <= emit ? frac_step : 4'd0;
            ovf_reg    <= emit && sat_step;
            send_reg   <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign field_valid     = fvalid_reg;
    assign field_id        = fid_reg;
    assign value_mantissa  = mant_reg;
    assign fraction_digits = fdig_reg;
    assign value_overflow  = ovf_reg;
    assign sentence_end    = send_reg;

endmodule

[tb/anemometer_field_parser_unit_tb.sv]
`timescale 1ns / 1ps
// anemometer_field_parser_unit_tb: drives directed and random sensor sentences byte by byte,
// predicts every emitted field in a local parser, and checks each result word in order.
// Depends on afp_pkg and anemometer_field_parser_unit.
module anemometer_field_parser_unit_tb;

    import afp_pkg::*;

    localparam int STALL_PCT   = 14;
    localparam int STUCK_LIMIT = 5000;
    localparam int RANDOM_BYTES = 550;

    typedef struct packed {
        logic [7:0] c;
        logic       last;
    } sentence_byte_t;

    typedef struct packed {
        logic                     valid;
        logic [3:0]               id;
        logic signed [MANT_W-1:0] mant;
        logic [3:0]               frac;
        logic                     ovf;
        logic                     eos;
    } field_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] char_byte = 8'd0;
    logic last_byte = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic field_valid;
    logic [3:0] field_id;
    logic signed [MANT_W-1:0] value_mantissa;
    logic [3:0] fraction_digits;
    logic value_overflow;
    logic sentence_end;

    sentence_byte_t pending_bytes[$];
    field_word_t    expected_fields[$];
    sentence_byte_t next_byte;
    field_word_t    new_field;
    field_word_t    want_field;

    phase_t           ph;
    logic [3:0]       cur_tag;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             pt_seen;
    logic [3:0]       frac_cnt;
    logic [3:0]       dig_cnt;
    logic             sat;

    int  bytes_in = 0;
    int  results_seen = 0;
    int  fields_seen = 0;
    int  overflow_seen = 0;
    int  sentences_seen = 0;
    int  mismatches = 0;
    int  stuck_cycles = 0;
    logic calm;

    assign calm = (bytes_in >= 200) && (bytes_in < 320);

    anemometer_field_parser_unit u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_byte       (char_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .field_valid     (field_valid),
        .field_id        (field_id),
        .value_mantissa  (value_mantissa),
        .fraction_digits (fraction_digits),
        .value_overflow  (value_overflow),
        .sentence_end    (sentence_end)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic byte_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic byte_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void clear_number();
        mag      = '0;
        neg      = 1'b0;
        pt_seen  = 1'b0;
        frac_cnt = 4'd0;
        dig_cnt  = 4'd0;
        sat      = 1'b0;
    endfunction

    function automatic void look_for_tag(input logic [7:0] c);
        logic [3:0] t;
        ph = PH_IDLE;
        if (!byte_is_space(c) && !byte_is_digit(c) && (c != CH_DOT) && (c != CH_MINUS))
        begin
            case (c)
                CH_S:    t = TAG_SPEED;
                CH_D:    t = TAG_DIR;
                CH_U:    t = TAG_U;
                CH_V:    t = TAG_V;
                CH_W:    t = TAG_W;
                CH_T:    t = TAG_TEMP;
                CH_H:    t = TAG_HUMIDITY;
                CH_R:    t = TAG_ROLL;
                CH_M:    t = TAG_MAGDIR;
                CH_P:    t = TAG_P;
                default: t = TAG_NONE;
            endcase
            if (t <= TAG_MAGDIR)
            begin
                cur_tag = t;
                clear_number();
                ph = PH_SKIP;
            end
            else if (t == TAG_P)
            begin
                clear_number();
                ph = PH_PSEL;
            end
        end
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'(c - CH_ZERO);
        if (!pt_seen && (mag == '0) && (d == 4'd0))
            return;
        if (dig_cnt >= DIGIT_MAX)
        begin
            mag = DIGIT_LIMIT;
            sat = 1'b1;
            return;
        end
        if (sat)
            return;
        mag     = MAG_W'(mag * 10 + d);
        dig_cnt = dig_cnt + 4'd1;
        if (pt_seen)
            frac_cnt = frac_cnt + 4'd1;
    endfunction

    // Advance the parser by one byte; return 1 when a result word is due.
    function automatic logic parse_byte(input logic [7:0] c, input logic last,
                                        output field_word_t r);
        logic emit;
        emit = 1'b0;
        case (ph)
            PH_SKIP:
                ph = PH_LEAD;
            PH_PSEL:
                if (c == CH_I)
                begin
                    cur_tag = TAG_PITCH;
                    ph = PH_LEAD;
                end
                else if (c == CH_SPACE)
                begin
                    cur_tag = TAG_PRESSURE;
                    ph = PH_LEAD;
                end
                else
                    look_for_tag(c);
            PH_LEAD:
                if (byte_is_space(c))
                    ;
                else if ((c == CH_PLUS) || (c == CH_MINUS))
                begin
                    neg = (c == CH_MINUS);
                    ph = PH_BODY;
                end
                else if (byte_is_digit(c))
                begin
                    add_digit(c);
                    ph = PH_BODY;
                end
                else if (c == CH_DOT)
                begin
                    pt_seen = 1'b1;
                    ph = PH_BODY;
                end
                else
                begin
                    emit = 1'b1;
                    ph = PH_IDLE;
                end
            PH_BODY:
                if (byte_is_digit(c))
                    add_digit(c);
                else if ((c == CH_DOT) && !pt_seen)
                    pt_seen = 1'b1;
                else
                begin
                    emit = 1'b1;
                    ph = PH_IDLE;
                end
            default:
                look_for_tag(c);
        endcase

        if (last && ((ph == PH_LEAD) || (ph == PH_BODY)))
            emit = 1'b1;

        r = '0;
        if (emit)
        begin
            r.valid = 1'b1;
            r.id    = cur_tag;
            r.mant  = neg ? MANT_W'(0) - MANT_W'(mag) : MANT_W'(mag);
            r.frac  = frac_cnt;
            r.ovf   = sat;
        end
        r.eos = last;

        if (last)
        begin
            ph = PH_IDLE;
            clear_number();
        end
        return emit || last;
    endfunction

    function automatic void compare_field(input string name, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic push_byte(input logic [7:0] c, input logic last);
        sentence_byte_t b;
        b.c = c;
        b.last = last;
        pending_bytes.push_back(b);
    endtask

    task automatic push_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i], last && (i == s.len() - 1));
        end
    endtask

    task automatic push_space();
        if ($urandom_range(0, 1) == 0)
            push_byte(CH_SPACE, 1'b0);
        else
            push_byte(8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
    endtask

    // Driver: present the next word once the slot is free; predict on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_byte <= 8'd0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (parse_byte(char_byte, last_byte, new_field))
                    expected_fields.push_back(new_field);
                bytes_in <= bytes_in + 1;
            end
            if (!in_valid || in_ready)
            begin
                if ((pending_bytes.size() != 0) &&
                    (calm || ($urandom_range(0, 99) >= STALL_PCT)))
                begin
                    next_byte = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    char_byte <= next_byte.c;
                    last_byte <= next_byte.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, check each accepted word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_fields.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, actual id %0d value %0d",
                             $time, field_id, value_mantissa);
                end
                else
                begin
                    want_field = expected_fields.pop_front();
                    if (want_field.valid)
                        fields_seen++;
                    if (want_field.ovf)
                        overflow_seen++;
                    if (want_field.eos)
                        sentences_seen++;
                    compare_field("field_valid", 32'(want_field.valid), 32'(field_valid));
                    compare_field("field_id", 32'(want_field.id), 32'(field_id));
                    compare_field("value_mantissa", 32'(want_field.mant),
                                  32'(value_mantissa));
                    compare_field("fraction_digits", 32'(want_field.frac),
                                  32'(fraction_digits));
                    compare_field("value_overflow", 32'(want_field.ovf), 32'(value_overflow));
                    compare_field("sentence_end", 32'(want_field.eos), 32'(sentence_end));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else if (rst_n && ((pending_bytes.size() != 0) || in_valid ||
                           (expected_fields.size() != 0)))
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int n_fields;
        int n_digits;
        int target;
        int total_bytes;

        ph = PH_IDLE;
        cur_tag = TAG_SPEED;
        clear_number();

        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("S,-0.05.", 1'b0);
        push_text("PX", 1'b0);
        push_text("M\t1234567890", 1'b1);

        target = RANDOM_BYTES;
        while (pending_bytes.size() < target)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            else
            begin
                n_fields = $urandom_range(1, 4);
                for (int f = 0; f < n_fields; f++)
                begin
                    sel = $urandom_range(0, 12);
                    case (sel)
                        0:  push_byte(CH_S, 1'b0);
                        1:  push_byte(CH_D, 1'b0);
                        2:  push_byte(CH_U, 1'b0);
                        3:  push_byte(CH_V, 1'b0);
                        4:  push_byte(CH_W, 1'b0);
                        5:  push_byte(CH_T, 1'b0);
                        6:  push_byte(CH_H, 1'b0);
                        7:  push_byte(CH_R, 1'b0);
                        8:  push_byte(CH_M, 1'b0);
                        9:  push_byte(CH_P, 1'b0);
                        10: push_byte(CH_P, 1'b0);
                        11: push_byte(CH_P, 1'b0);
                        default: push_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
                    endcase
                    if (sel == 9)
                        push_byte(CH_I, 1'b0);
                    else if (sel == 10)
                        push_byte(CH_SPACE, 1'b0);
                    else if ((sel == 7) && $urandom_range(0, 1))
                        push_byte(CH_O, 1'b0);
                    else if ((sel == 8) && $urandom_range(0, 1))
                        push_byte(CH_D, 1'b0);
                    else if ($urandom_range(0, 3) == 0)
                        push_byte(8'($urandom_range(0, 255)), 1'b0);
                    else
                        push_byte(8'h2C, 1'b0);

                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2))
                            push_space();
                    sel = $urandom_range(0, 3);
                    if (sel == 0)
                        push_byte(CH_MINUS, 1'b0);
                    else if (sel == 1)
                        push_byte(CH_PLUS, 1'b0);
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 2))
                            push_byte(CH_ZERO, 1'b0);
                    n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12)
                                                           : $urandom_range(0, 4);
                    repeat (n_digits)
                        push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                    if ($urandom_range(0, 1))
                    begin
                        push_byte(CH_DOT, 1'b0);
                        repeat ($urandom_range(0, 4))
                            push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                        if ($urandom_range(0, 7) == 0)
                            push_byte(CH_DOT, 1'b0);
                    end

                    if (f < n_fields - 1)
                    begin
                        sel = $urandom_range(0, 3);
                        if (sel == 0)
                            push_byte(8'h2C, 1'b0);
                        else if (sel == 1)
                            push_space();
                        else if (sel == 2)
                            push_byte(CH_SPACE, 1'b0);
                    end
                end
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    push_byte(CH_CR, 1'b1);
                else if (sel == 1)
                    push_byte(8'h0A, 1'b1);
                else
                    push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1);
            end
        end
        total_bytes = pending_bytes.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while ((bytes_in < total_bytes) || (expected_fields.size() != 0))
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Drove %0d bytes; checked %0d result words: %0d fields, %0d saturated,",
                 bytes_in, results_seen, fields_seen, overflow_seen);
        $display("%0d sentence ends, %0d mismatches.", sentences_seen, mismatches);
        if ((mismatches == 0) && (expected_fields.size() == 0))
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
